### sv/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants for the RGB box blur unit
// Holds the payload structs, register indexes and the controller states.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int CH_W  = 8;
	localparam int SUM_W = 16;
	localparam int DIV_W = 8;
	localparam int POS_W = 20;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0]  red_avg;
		logic [CH_W-1:0]  green_avg;
		logic [CH_W-1:0]  blue_avg;
		logic [POS_W-1:0] centre_position;
	} pix_out_t;

	typedef logic [SUM_W-1:0] sum3_t [3];

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} ctrl_state_t;

endpackage

### sv/bbr_ram.sv
// ----------------------------------------------------------------------------
// bbr_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 14350
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/bbr_div.sv
// ----------------------------------------------------------------------------
// bbr_div: three-lane restoring divider
// Divides three channel sums by one shared divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bbr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bbr_pkg::SUM_W-1:0]   dividend [3],
	input  logic [bbr_pkg::DIV_W-1:0]   divisor,
	output logic                        done,
	output logic [bbr_pkg::CH_W-1:0]    quotient [3]
);
	import bbr_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]    div_q;
	logic [SUM_W-1:0]    num_q [3];
	logic [DIV_W-1:0]    rem_q [3];
	logic [SUM_W-1:0]    quo_q [3];
	logic [DIV_W:0]      trial [3];

	// Shift in the next dividend bit and test against the divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], num_q[i][SUM_W-1]};
		end
	end

	// Control: counts the steps of a run and pulses done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath of the three lanes
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int i = 0; i < 3; i++) begin
				num_q[i] <= dividend[i];
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				num_q[i] <= {num_q[i][SUM_W-2:0], 1'b0};
				if (trial[i] >= {1'b0, div_q}) begin
					rem_q[i] <= DIV_W'(trial[i] - {1'b0, div_q});
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= DIV_W'(trial[i]);
					quo_q[i] <= {quo_q[i][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quotient[i] = quo_q[i][CH_W-1:0];
		end
	end

endmodule

### sv/box_blur_rgb_window_unit.sv
// ----------------------------------------------------------------------------
// box_blur_rgb_window_unit: RGB box blur over a raster pixel stream
// Keeps recent pixels in a circular line store and gives window means.
// ----------------------------------------------------------------------------
//  Channel  | Signals                              | Payload
//  ---------+--------------------------------------+-------------------------
//  in       | in_valid, in_ready, in_data          | pix_in_t
//  out      | out_valid, out_ready, out_data       | pix_out_t
//  config   | psel, penable, pwrite, paddr, pwdata | radius, width, height
//
// A pixel that gives no result leaves the input open. A pixel that gives a
// result is taken, then its window taps are read from the line store (one
// read port, one tap a cycle), the sums are divided (start, one step per
// dividend bit, done) and the result is committed before the next pixel.
// Reset clears control and position; the line store needs no clearing.
// The input is closed after reset and after a register write while the
// derived settings reload.
// A waiting result stalls the commit only; the next pixel enters once the
// result has moved to the output register.
// ----------------------------------------------------------------------------
module box_blur_rgb_window_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bbr_pkg::pix_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bbr_pkg::pix_out_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import bbr_pkg::*;

	localparam int DEPTH = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS);
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = 22;

	// Configuration registers
	logic [2:0]  radius_q;
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic        settle_q;

	// Derived settings
	logic [10:0]   w_q;
	logic [PW-1:0] total_q;
	logic [15:0]   pad_q;
	logic [15:0]   pad2_q;
	logic [3:0]    side_m1_q;
	logic [DIV_W-1:0] count_q;
	logic [2:0]    r_c;
	logic [10:0]   w_c;
	logic [10:0]   h_c;
	logic [3:0]    side_c;
	logic [15:0]   pad_c;

	// Control and datapath
	ctrl_state_t   state_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] p_q;
	logic [PW-1:0] p_c;
	logic          need_c;
	logic [AW-1:0] ws_q;
	logic [AW-1:0] tap_q;
	logic [AW-1:0] row_q;
	logic [AW:0]   start_c;
	logic [AW:0]   row_nx_c;
	logic [3:0]    xi_q;
	logic [3:0]    yi_q;
	logic          last_c;
	pix_in_t       pix_q;
	logic          rd_v_s1;
	logic          div_go_q;
	logic [SUM_W-1:0] sum_q [3];
	logic [CH_W-1:0]  quo [3];
	logic          div_done;
	logic          div_start;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [23:0]   mem_wdata;
	logic          mem_re;
	logic [23:0]   mem_rdata;
	logic          accept_in;
	logic          commit;
	logic          out_valid_q;
	pix_out_t      out_q;

	// APB port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 3'd1;
			width_q  <= 11'd1024;
			height_q <= 11'd1024;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_RADIUS: radius_q <= pwdata[2:0];
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// The input waits after reset or a write so the derived values reload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 1'b1;
		end else begin
			settle_q <= psel && penable && pwrite;
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RADIUS: prdata = {29'd0, radius_q};
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {21'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	// Clamp the settings to the supported maxima; a zero width or height counts as one
	always_comb begin
		r_c = ({29'd0, radius_q} > 32'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_q;
		if (width_q == '0) begin
			w_c = 11'd1;
		end else if ({21'd0, width_q} > 32'(MAX_WIDTH)) begin
			w_c = 11'(MAX_WIDTH);
		end else begin
			w_c = width_q;
		end
		if (height_q == '0) begin
			h_c = 11'd1;
		end else if ({21'd0, height_q} > 32'(MAX_HEIGHT)) begin
			h_c = 11'(MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
		side_c = {r_c, 1'b1};
		pad_c  = 16'(r_c) * 16'(w_c) + 16'(r_c);
	end

	// Registered derived values, all loaded in the cycle after the settings change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= 11'd1;
			total_q   <= '0;
			pad_q     <= '0;
			pad2_q    <= '0;
			side_m1_q <= '0;
			count_q   <= 8'd1;
		end else begin
			w_q       <= w_c;
			total_q   <= PW'(w_c) * PW'(h_c);
			pad_q     <= pad_c;
			pad2_q    <= {pad_c[14:0], 1'b0};
			side_m1_q <= {r_c, 1'b0};
			count_q   <= DIV_W'(side_c) * DIV_W'(side_c);
		end
	end

	// Position of the incoming pixel, whether it completes a window, and the window walk addresses
	always_comb begin
		p_c     = (pos_q >= total_q) ? '0 : pos_q;
		need_c  = p_c >= {6'd0, pad2_q};
		start_c = {1'b0, ws_q} + (AW+1)'(DEPTH) - (AW+1)'(pad2_q);
		if (start_c >= (AW+1)'(DEPTH)) begin
			start_c = start_c - (AW+1)'(DEPTH);
		end
		row_nx_c = {1'b0, row_q} + (AW+1)'(w_q);
		if (row_nx_c >= (AW+1)'(DEPTH)) begin
			row_nx_c = row_nx_c - (AW+1)'(DEPTH);
		end
		last_c = (xi_q == side_m1_q) && (yi_q == side_m1_q);
	end

	assign in_ready  = (state_q == ST_IDLE) && !settle_q;
	assign accept_in = in_valid && in_ready;
	assign commit    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign div_start = div_go_q;
	assign mem_re    = (state_q == ST_ACC) && !last_c;
	assign mem_we    = (accept_in && !need_c) || commit;
	assign mem_waddr = ws_q;
	assign mem_wdata = accept_in ? in_data : pix_q;

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			ws_q     <= '0;
			rd_v_s1  <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
			// The divider starts once the last tap has entered the sums
			div_go_q <= (state_q == ST_ACC) && last_c;
			if (mem_we) begin
				ws_q <= (ws_q == AW'(DEPTH - 1)) ? '0 : ws_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						if (need_c) begin
							state_q <= ST_ACC;
						end else begin
							pos_q <= (p_c + 1'b1 >= total_q) ? '0 : p_c + 1'b1;
						end
					end
				end
				ST_ACC: begin
					if (last_c) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						pos_q   <= (p_q + 1'b1 >= total_q) ? '0 : p_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Tap walk over the window and the channel sums
	always_ff @(posedge clk) begin
		if (accept_in) begin
			pix_q <= in_data;
			p_q   <= p_c;
			tap_q <= AW'(start_c);
			row_q <= AW'(start_c);
			xi_q  <= '0;
			yi_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
		end else if (state_q == ST_ACC) begin
			if (xi_q == side_m1_q) begin
				xi_q  <= '0;
				yi_q  <= yi_q + 1'b1;
				row_q <= AW'(row_nx_c);
				tap_q <= AW'(row_nx_c);
			end else begin
				xi_q  <= xi_q + 1'b1;
				tap_q <= (tap_q == AW'(DEPTH - 1)) ? '0 : tap_q + 1'b1;
			end
			sum_q[0] <= sum_q[0] + (rd_v_s1 ? SUM_W'(mem_rdata[23:16]) : '0)
				+ (last_c ? SUM_W'(pix_q.red_in) : '0);
			sum_q[1] <= sum_q[1] + (rd_v_s1 ? SUM_W'(mem_rdata[15:8]) : '0)
				+ (last_c ? SUM_W'(pix_q.green_in) : '0);
			sum_q[2] <= sum_q[2] + (rd_v_s1 ? SUM_W'(mem_rdata[7:0]) : '0)
				+ (last_c ? SUM_W'(pix_q.blue_in) : '0);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.red_avg         <= quo[0];
			out_q.green_avg       <= quo[1];
			out_q.blue_avg        <= quo[2];
			out_q.centre_position <= POS_W'(p_q - {6'd0, pad_q});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bbr_ram #(
		.WIDTH(24),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(tap_q),
		.rdata(mem_rdata)
	);

	bbr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (count_q),
		.done    (div_done),
		.quotient(quo)
	);

	// Checks
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_DONE))
		else $error("line store written outside idle or commit");
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> ({1'b0, tap_q} < (AW+1)'(DEPTH)))
		else $error("tap address beyond line store");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside division phase");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB box blur window unit
// Streams raster pixels through several radius and frame settings, predicts
// each window mean from a private copy of the pixel history and checks every
// output transaction in order.
// ----------------------------------------------------------------------------
module tb_top;

	import bbr_pkg::*;

	localparam int HIST_DEPTH  = 14350;
	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 1024;
	localparam int MAX_R       = 7;
	localparam int SETTLE      = 300;
	localparam int STALL_LIMIT = 5000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	pix_in_t     in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pix_out_t    out_data;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	// Pixels waiting to be sent and window means waiting to come back
	pix_in_t  pixel_queue[$];
	pix_out_t mean_queue[$];

	// Private copy of the block's state
	pix_in_t     pixel_hist[HIST_DEPTH];
	int unsigned hist_slot = 0;
	int unsigned raster_pos = 0;
	int unsigned shadow_radius = 1;
	int unsigned shadow_width = 1024;
	int unsigned shadow_height = 1024;

	int  send_idle_pct = 12;
	int  recv_idle_pct = 12;
	logic in_took = 1'b0;
	int  errors = 0;
	int  quiet_cycles = 0;

	box_blur_rgb_window_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Window mean prediction for one accepted pixel; pushes a result if one is due.
	task automatic predict_window_mean(input pix_in_t px);
		int unsigned r, w, h, total, pad, side, k, slot, s0, s1, s2;
		pix_in_t v;
		pix_out_t res;
		r = (shadow_radius > MAX_R) ? MAX_R : shadow_radius;
		w = (shadow_width == 0) ? 1 : ((shadow_width > MAX_W) ? MAX_W : shadow_width);
		h = (shadow_height == 0) ? 1 : ((shadow_height > MAX_H) ? MAX_H : shadow_height);
		total = w * h;
		pad = r * w + r;
		if (raster_pos >= total)
			raster_pos = 0;
		if (raster_pos >= 2 * pad) begin
			side = 2 * r + 1;
			s0 = 0;
			s1 = 0;
			s2 = 0;
			for (int yi = 0; yi < side; yi++) begin
				for (int xi = 0; xi < side; xi++) begin
					k = 2 * pad - (yi * w + xi);
					if (k == 0) begin
						v = px;
					end else begin
						slot = (hist_slot + HIST_DEPTH - (k % HIST_DEPTH)) % HIST_DEPTH;
						v = pixel_hist[slot];
					end
					s0 += v.red_in;
					s1 += v.green_in;
					s2 += v.blue_in;
				end
			end
			res.red_avg         = 8'(s0 / (side * side));
			res.green_avg       = 8'(s1 / (side * side));
			res.blue_avg        = 8'(s2 / (side * side));
			res.centre_position = 20'(raster_pos - pad);
			mean_queue.push_back(res);
		end
		pixel_hist[hist_slot] = px;
		hist_slot = (hist_slot + 1) % HIST_DEPTH;
		raster_pos++;
		if (raster_pos >= total)
			raster_pos = 0;
	endtask

	// Random pixel, with channels often pinned to their extremes
	function automatic pix_in_t random_pixel();
		pix_in_t px;
		px = pix_in_t'(24'($urandom));
		if ($urandom_range(7) == 0) px.red_in   = $urandom_range(1) ? 8'hFF : 8'h00;
		if ($urandom_range(7) == 0) px.green_in = $urandom_range(1) ? 8'hFF : 8'h00;
		if ($urandom_range(7) == 0) px.blue_in  = $urandom_range(1) ? 8'hFF : 8'h00;
		return px;
	endfunction

	// Register write: setup cycle, then access cycle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_RADIUS: shadow_radius = value & 32'h7;
			REG_WIDTH:  shadow_width  = value & 32'h7FF;
			REG_HEIGHT: shadow_height = value & 32'h7FF;
			default: ;
		endcase
	endtask

	// Wait until every pixel is sent and every mean has come, then let the block settle.
	task automatic drain();
		while (pixel_queue.size() != 0 || in_valid || mean_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned r, input int unsigned w,
		input int unsigned h, input int n_items);
		write_reg(REG_RADIUS, r | ($urandom << 3));
		write_reg(REG_WIDTH,  w | ($urandom << 11));
		write_reg(REG_HEIGHT, h | ($urandom << 11));
		for (int i = 0; i < n_items; i++)
			pixel_queue.push_back(random_pixel());
		drain();
	endtask

	// Input driver: a new transaction goes out only once the last one was taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data  <= pixel_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: predict on accepted pixels, check accepted results.
	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			predict_window_mean(in_data);
		if (arst_n && out_valid && out_ready) begin
			if (mean_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, out_data);
				errors++;
			end else begin
				pix_out_t want;
				want = mean_queue.pop_front();
				if (out_data.red_avg !== want.red_avg) begin
					$display("%0t: red_avg expected %h actual %h",
						$time, want.red_avg, out_data.red_avg);
					errors++;
				end
				if (out_data.green_avg !== want.green_avg) begin
					$display("%0t: green_avg expected %h actual %h",
						$time, want.green_avg, out_data.green_avg);
					errors++;
				end
				if (out_data.blue_avg !== want.blue_avg) begin
					$display("%0t: blue_avg expected %h actual %h",
						$time, want.blue_avg, out_data.blue_avg);
					errors++;
				end
				if (out_data.centre_position !== want.centre_position) begin
					$display("%0t: centre_position expected %0d actual %0d",
						$time, want.centre_position, out_data.centre_position);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("** box_blur_rgb_window_unit: FAILED **");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		pix_in_t px;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pixels at the reset settings: extremes and bit patterns
		pixel_queue.push_back('{8'h00, 8'h00, 8'h00});
		pixel_queue.push_back('{8'hFF, 8'hFF, 8'hFF});
		pixel_queue.push_back('{8'hAA, 8'h55, 8'hAA});
		pixel_queue.push_back('{8'h55, 8'hAA, 8'h55});
		for (int b = 0; b < 8; b++) begin
			px = '{8'h01 << b, 8'h80 >> b, 8'hFF ^ (8'h01 << b)};
			pixel_queue.push_back(px);
		end
		drain();

		// Every pixel a result; widest row
		run_phase(0, 1024, 2, 150);
		// Small frame, random content
		run_phase(1, 8, 8, 300);
		// Largest radius, no sender or receiver idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(7, 16, 16, 300);
		send_idle_pct = 12;
		recv_idle_pct = 12;
		// Width of zero acts as one; tallest frame
		run_phase(2, 0, 1024, 200);
		// Oversized width saturates, zero height acts as one: no results
		run_phase(3, 2047, 0, 50);
		// Odd frame, window wraps over row ends
		run_phase(1, 5, 7, 400);
		// Tiny frame, frequent restarts
		run_phase(0, 3, 3, 150);
		// Saturated height with radius change
		run_phase(2, 6, 2047, 200);

		if (errors == 0 && mean_queue.size() == 0) begin
			$display("** box_blur_rgb_window_unit: PASSED **");
		end else begin
			if (mean_queue.size() != 0)
				$display("%0t: %0d results never arrived", $time, mean_queue.size());
			$display("** box_blur_rgb_window_unit: FAILED **");
		end
		$finish;
	end

endmodule
